// ===== rtl/pesn_pkg.sv =====
`timescale 1ns / 1ps

package pesn_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } state_type;

   localparam int unsigned ROUNDS    = 80;
   localparam int unsigned ROUND_W   = $clog2(ROUNDS);
   localparam int unsigned WIN_DEPTH = 16;
   localparam int unsigned MEID_W    = 56;
   localparam int unsigned ESN_W     = 32;

   // initial hash values
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   // round constants
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // fixed manufacturer code in the top byte
   localparam logic [7:0] ESN_MFR_CODE = 8'h80;

   // padding byte and message length for a 7-byte message
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [31:0] MSG_BITS = 32'd56;

   // round function and constant for one round
   function automatic logic [63:0] round_fk(input logic [ROUND_W-1:0] t,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
      logic [31:0] f;
      logic [31:0] k;
      begin
         priority if (t < ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (t < ROUND_W'(40)) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (t < ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         round_fk = {f, k};
      end
   endfunction

endpackage

// ===== rtl/pseudo_esn_from_meid_core.sv =====
`timescale 1ns / 1ps

// Pseudo-ESN from MEID: SHA-1 over the 7 MEID bytes, low 24 bits of the
// fifth digest word with 0x80 as the top byte.
//
// Request channel: a request is taken at a rising edge where start is high
// and busy is low; req_meid_value is sampled at that edge. busy stays high
// while the request is worked on.
// Result channel: rsp_strobe is high for exactly one cycle with the result on
// rsp_pseudo_esn; the receiver cannot hold it off, so it must take it then.
//
// Timing: a new request may be accepted while rsp_strobe shows the result of
// the last one, so the block does not take a new request before
// it is through with the last. The time per request is set by the single
// SHA-1 round unit (one round per cycle, 80 rounds) and then the done state,
// which forms the final digest add and loads the result register.
//
// Reset (synchronous, active high) returns the sequencer to idle and drops
// the strobe; a request in flight is discarded.

module pseudo_esn_from_meid_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pesn_pkg::MEID_W-1:0]   req_meid_value,
   output logic                          rsp_strobe,
   output logic [pesn_pkg::ESN_W-1:0]    rsp_pseudo_esn
);

   pesn_pkg::state_type state_ff, state_in;

   logic [pesn_pkg::ROUND_W-1:0] round_ff, round_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] win_ff [pesn_pkg::WIN_DEPTH];
   logic [31:0] win_in [pesn_pkg::WIN_DEPTH];
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [pesn_pkg::ESN_W-1:0] rsp_esn_ff, rsp_esn_in;

   logic [63:0] fk;
   logic [31:0] round_sum;
   logic [31:0] sched_word;
   logic [23:0] digest_e;
   logic        accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != pesn_pkg::ST_IDLE);

   // shared round unit
   always_comb begin
      fk        = pesn_pkg::round_fk(round_ff, b_ff, c_ff, d_ff);
      round_sum = {a_ff[26:0], a_ff[31:27]} + fk[63:32] + e_ff + fk[31:0] + win_ff[0];
   end

   // next schedule word from the sliding window
   always_comb begin
      logic [31:0] x;
      x          = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      sched_word = {x[30:0], x[31]};
   end

   // only the low 24 bits of the final digest word are kept
   assign digest_e = pesn_pkg::H4[23:0] + e_ff[23:0];

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      win_in        = win_ff;
      rsp_strobe_in = 1'b0;
      rsp_esn_in    = rsp_esn_ff;
      unique case (state_ff)
         pesn_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pesn_pkg::ST_ROUND;
               round_in = '0;
               a_in     = pesn_pkg::H0;
               b_in     = pesn_pkg::H1;
               c_in     = pesn_pkg::H2;
               d_in     = pesn_pkg::H3;
               e_in     = pesn_pkg::H4;
               for (int i = 0; i < pesn_pkg::WIN_DEPTH; i++) begin
                  win_in[i] = '0;
               end
               win_in[0] = req_meid_value[55:24];
               win_in[1] = {req_meid_value[23:0], pesn_pkg::PAD_BYTE};
               win_in[pesn_pkg::WIN_DEPTH-1] = pesn_pkg::MSG_BITS;
            end
         end
         pesn_pkg::ST_ROUND: begin
            a_in = round_sum;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            for (int i = 0; i < pesn_pkg::WIN_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[pesn_pkg::WIN_DEPTH-1] = sched_word;
            round_in = round_ff + 1'b1;
            if (round_ff == pesn_pkg::ROUND_W'(pesn_pkg::ROUNDS - 1)) begin
               state_in = pesn_pkg::ST_DONE;
            end
         end
         pesn_pkg::ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_esn_in    = {pesn_pkg::ESN_MFR_CODE, digest_e};
            state_in      = pesn_pkg::ST_IDLE;
         end
         default: begin
            state_in = pesn_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pesn_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      round_ff   <= round_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      win_ff     <= win_in;
      rsp_esn_ff <= rsp_esn_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_pseudo_esn = rsp_esn_ff;

`ifndef SYNTHESIS
   // an accepted request keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request");

   // a result is only shown once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // results carry the fixed top byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pseudo_esn[31:24] == pesn_pkg::ESN_MFR_CODE))
      else $error("bad manufacturer code");

   // one result per request; the strobe does not repeat back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");
`endif

endmodule
